// ===== design/fce_pkg.sv =====
// Shared types and constants for the FAT16 chain extent builder.
package fce_pkg;

	localparam logic [15:0] END_MARK     = 16'hFFF8;
	localparam int          RESULT_LIMIT = 16;

	localparam logic [1:0] ST_END = 2'd0;
	localparam logic [1:0] ST_CAP = 2'd1;
	localparam logic [1:0] ST_OOR = 2'd2;

	typedef enum logic [1:0] {
		EMIT_MID,
		EMIT_END,
		EMIT_CAP,
		EMIT_OOR
	} emit_kind_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       read;
		logic       advance;
		logic       emit;
		emit_kind_t kind;
	} fce_cmd_t;

	typedef struct packed {
		logic beyond;
		logic end_mark;
		logic consec;
		logic cap_full;
		logic out_free;
	} fce_stat_t;

endpackage

// ===== design/fce_ctrl.sv =====
// Walk controller: sequences table loads, chain fetches and extent emission.
module fce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              mode,
	output logic              in_ready,
	input  fce_pkg::fce_stat_t stat,
	output fce_pkg::fce_cmd_t  cmd
);
	import fce_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EVAL
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.kind = EMIT_MID;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = ~mode;
					cmd.start = mode;
				end
			end
			S_FETCH: begin
				if (stat.beyond) begin
					cmd.emit = stat.out_free;
					cmd.kind = EMIT_OOR;
				end else begin
					cmd.read = 1'b1;
				end
			end
			S_EVAL: begin
				if (stat.end_mark) begin
					cmd.emit = stat.out_free;
					cmd.kind = EMIT_END;
				end else if (stat.consec) begin
					cmd.advance = 1'b1;
				end else if (stat.cap_full) begin
					cmd.emit = stat.out_free;
					cmd.kind = EMIT_CAP;
				end else begin
					cmd.emit = stat.out_free;
					cmd.kind = EMIT_MID;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (cmd.read) state_q <= S_EVAL;
					else if (cmd.emit) state_q <= S_IDLE;
				end
				S_EVAL: begin
					if (cmd.advance) state_q <= S_FETCH;
					else if (cmd.emit) begin
						state_q <= (cmd.kind == EMIT_MID) ? S_FETCH : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/fce_dpath.sv =====
// Datapath: FAT table memory, walk registers and the result output register.
module fce_dpath #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MAX_EXTENTS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fce_pkg::fce_cmd_t  cmd,
	output fce_pkg::fce_stat_t stat,
	input  logic [11:0]        entry_index,
	input  logic [15:0]        entry_value,
	input  logic [15:0]        start_cluster,
	input  logic [4:0]         max_extents,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        base_cluster,
	output logic [15:0]        run_extra,
	output logic               last,
	output logic [1:0]         walk_status,
	output logic [15:0]        resume_cluster
);
	import fce_pkg::*;

	localparam int AW      = $clog2(TABLE_ENTRIES);
	localparam int CAP_LIM = (MAX_EXTENTS < RESULT_LIMIT) ? MAX_EXTENTS : RESULT_LIMIT;

	logic [15:0] mem [TABLE_ENTRIES];
	logic [15:0] rdata_q;
	logic [15:0] cur_q;
	logic [15:0] base_q;
	logic [15:0] run_q;
	logic [4:0]  n_q;
	logic [4:0]  cap_q;
	logic [4:0]  cap_in;
	logic [16:0] idx_ext;
	logic [16:0] cur_ext;
	logic        idx_ok;

	assign idx_ext = 17'(entry_index);
	assign cur_ext = {1'b0, cur_q};
	assign idx_ok  = idx_ext < 17'(TABLE_ENTRIES);

	always_comb begin
		if (max_extents == 5'd0) cap_in = 5'd1;
		else if (max_extents > 5'(CAP_LIM)) cap_in = 5'(CAP_LIM);
		else cap_in = max_extents;
	end

	assign stat.beyond   = cur_ext >= 17'(TABLE_ENTRIES);
	assign stat.end_mark = rdata_q >= END_MARK;
	assign stat.consec   = {1'b0, rdata_q} == (cur_ext + 17'd1);
	assign stat.cap_full = ({1'b0, n_q} + 6'd1) >= {1'b0, cap_q};
	assign stat.out_free = ~out_valid | out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok) mem[idx_ext[AW-1:0]] <= entry_value;
	end

	always_ff @(posedge clk) begin
		if (cmd.read) rdata_q <= mem[cur_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			base_q <= '0;
			run_q <= '0;
			n_q <= '0;
			cap_q <= 5'd1;
		end else if (cmd.start) begin
			cur_q <= start_cluster;
			base_q <= start_cluster;
			run_q <= '0;
			n_q <= '0;
			cap_q <= cap_in;
		end else if (cmd.advance) begin
			cur_q <= rdata_q;
			run_q <= run_q + 16'd1;
		end else if (cmd.emit && cmd.kind == EMIT_MID) begin
			cur_q <= rdata_q;
			base_q <= rdata_q;
			run_q <= '0;
			n_q <= n_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			base_cluster <= base_q;
			run_extra <= run_q;
			last <= (cmd.kind != EMIT_MID);
			resume_cluster <= '0;
			case (cmd.kind)
				EMIT_MID: walk_status <= ST_END;
				EMIT_END: walk_status <= ST_END;
				EMIT_CAP: begin
					walk_status <= ST_CAP;
					resume_cluster <= rdata_q;
				end
				EMIT_OOR: walk_status <= ST_OOR;
				default:  walk_status <= ST_END;
			endcase
		end
	end

endmodule

// ===== design/fat16_chain_extent_builder_core.sv =====
// FAT16 chain extent builder: top level joining the walk controller and datapath.
//
// Usage: one request channel (in_valid/in_ready) and one result channel
// (out_valid/out_ready). A request with mode 0 writes entry_value into table
// entry entry_index and produces no result; indexes at or past
// TABLE_ENTRIES are dropped. A request with mode 1 walks the cluster chain
// from start_cluster and returns one result per extent, the final one with
// last set, its walk_status and, on capacity exhaustion, resume_cluster.
// A walk handles each table entry with a table read step followed by an
// evaluate step on the registered read data, and an extent waits to be emitted
// while the output register is full; each result shows up on the output
// register the cycle after its extent closes. in_ready stays low for the whole
// walk. A result held by a stalled receiver blocks the next extent only; the
// walk resumes as soon as the output register frees up.
// Reset clears control state and the output valid; table contents are
// undefined until loaded, and no clearing pass runs.
module fat16_chain_extent_builder_core #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MAX_EXTENTS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [11:0] entry_index,
	input  logic [15:0] entry_value,
	input  logic [15:0] start_cluster,
	input  logic [4:0]  max_extents,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] base_cluster,
	output logic [15:0] run_extra,
	output logic        last,
	output logic [1:0]  walk_status,
	output logic [15:0] resume_cluster
);
	import fce_pkg::*;

	fce_cmd_t  cmd;
	fce_stat_t stat;

	fce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fce_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_EXTENTS   (MAX_EXTENTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.start_cluster  (start_cluster),
		.max_extents    (max_extents),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.base_cluster   (base_cluster),
		.run_extra      (run_extra),
		.last           (last),
		.walk_status    (walk_status),
		.resume_cluster (resume_cluster)
	);

	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> !in_ready)
		else $error("walk request did not block input");

	a_mid_extent_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> walk_status == ST_END && resume_cluster == 16'd0)
		else $error("intermediate extent carries status");

	a_resume_only_on_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && walk_status != ST_CAP |-> resume_cluster == 16'd0)
		else $error("resume cluster set without capacity status");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid || out_ready)
		else $error("extent emitted over a pending result");

endmodule

// ===== sim/fat16_chain_extent_builder_core_tb.sv =====
// Testbench for the FAT16 chain extent builder: random table loads and chain walks, scoreboarded.
module fat16_chain_extent_builder_core_tb;
	import fce_pkg::*;

	localparam int TABLE_ENTRIES = 4096;
	localparam int MAX_EXTENTS   = 16;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int DRAIN_CYCLES  = 50;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_PRINTS    = 40;
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_WALK   = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [11:0] idx;
		logic [15:0] val;
		logic [15:0] start;
		logic [4:0]  cap;
	} request_t;

	typedef struct packed {
		logic [15:0] base;
		logic [15:0] run;
		logic        last;
		logic [1:0]  status;
		logic [15:0] resume;
	} extent_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = MODE_LOAD;
	logic [11:0] entry_index = '0;
	logic [15:0] entry_value = '0;
	logic [15:0] start_cluster = '0;
	logic [4:0]  max_extents = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] base_cluster;
	logic [15:0] run_extra;
	logic        last;
	logic [1:0]  walk_status;
	logic [15:0] resume_cluster;

	request_t    pend_q[$];
	extent_t     extent_q[$];
	extent_t     want;
	logic [15:0] fat_model [0:TABLE_ENTRIES-1];
	bit          gen_written [0:TABLE_ENTRIES-1];
	int          used_q[$];
	int          pushed;
	int          err_count = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	logic        hold_arm = 1'b0;
	logic        hold_used = 1'b0;

	fat16_chain_extent_builder_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .entry_index(entry_index), .entry_value(entry_value),
		.start_cluster(start_cluster), .max_extents(max_extents),
		.out_valid(out_valid), .out_ready(out_ready),
		.base_cluster(base_cluster), .run_extra(run_extra), .last(last),
		.walk_status(walk_status), .resume_cluster(resume_cluster)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch %s: got %0d expected %0d", what, got, exp_val);
	endtask

	task automatic add_extent(input int base, input int run, input logic fin,
			input logic [1:0] status, input int resume);
		extent_t e;
		e.base   = base[15:0];
		e.run    = run[15:0];
		e.last   = fin;
		e.status = status;
		e.resume = resume[15:0];
		extent_q.push_back(e);
	endtask

	task automatic predict_extents(input logic [15:0] first, input logic [4:0] cap_in);
		int cap, cur, nxt, base, run, n;
		bit done;
		cap = (cap_in == 0) ? 1 : int'(cap_in);
		if (cap > MAX_EXTENTS) cap = MAX_EXTENTS;
		if (cap > RESULT_LIMIT) cap = RESULT_LIMIT;
		cur = first;
		base = cur;
		run = 0;
		n = 0;
		done = 0;
		while (!done) begin
			if (cur >= TABLE_ENTRIES) begin
				add_extent(base, run, 1'b1, ST_OOR, 0);
				done = 1;
			end else begin
				nxt = fat_model[cur];
				if (nxt >= int'(END_MARK)) begin
					add_extent(base, run, 1'b1, ST_END, 0);
					done = 1;
				end else if (nxt == cur + 1) begin
					run = (run + 1) & 16'hFFFF;
					cur = nxt;
				end else if (n + 1 >= cap) begin
					add_extent(base, run, 1'b1, ST_CAP, nxt);
					done = 1;
				end else begin
					add_extent(base, run, 1'b0, ST_END, 0);
					n++;
					base = nxt;
					run = 0;
					cur = nxt;
				end
			end
		end
	endtask

	task automatic take_request();
		if (mode == MODE_LOAD) begin
			if (entry_index < TABLE_ENTRIES)
				fat_model[entry_index] = entry_value;
		end else begin
			predict_extents(start_cluster, max_extents);
		end
	endtask

	task automatic check_extent();
		if (extent_q.size() == 0) begin
			report_mismatch("extent with nothing pending", base_cluster, -1);
		end else begin
			want = extent_q.pop_front();
			if (base_cluster !== want.base)
				report_mismatch("base_cluster", base_cluster, want.base);
			if (run_extra !== want.run)
				report_mismatch("run_extra", run_extra, want.run);
			if (last !== want.last)
				report_mismatch("last", last, want.last);
			if (walk_status !== want.status)
				report_mismatch("walk_status", walk_status, want.status);
			if (resume_cluster !== want.resume)
				report_mismatch("resume_cluster", resume_cluster, want.resume);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				take_request();
			if (pend_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				request_t r;
				r = pend_q.pop_front();
				in_valid      <= 1'b1;
				mode          <= r.mode;
				entry_index   <= r.idx;
				entry_value   <= r.val;
				start_cluster <= r.start;
				max_extents   <= r.cap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, armed once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
			if (out_valid && out_ready)
				check_extent();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL fat16_chain_extent_builder_core");
			$finish;
		end
	end

	task automatic push_load(input int idx, input int val);
		request_t r;
		r.mode  = MODE_LOAD;
		r.idx   = idx[11:0];
		r.val   = val[15:0];
		r.start = $urandom;
		r.cap   = $urandom;
		pend_q.push_back(r);
		pushed++;
		if (!gen_written[idx]) begin
			gen_written[idx] = 1;
			used_q.push_back(idx);
		end
	endtask

	task automatic push_walk(input int first, input int cap);
		request_t r;
		r.mode  = MODE_WALK;
		r.idx   = $urandom;
		r.val   = $urandom;
		r.start = first[15:0];
		r.cap   = cap[4:0];
		pend_q.push_back(r);
		pushed++;
	endtask

	function automatic int pick_written();
		return used_q[$urandom_range(0, used_q.size() - 1)];
	endfunction

	function automatic int pick_cap();
		return ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(0, 31);
	endfunction

	// every written entry points to a written entry or past the table
	task automatic add_chain();
		int links[$];
		int len, cur, term, k, sel;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
		cur = $urandom_range(0, TABLE_ENTRIES - 1);
		links.push_back(cur);
		for (k = 1; k < len; k++) begin
			if ($urandom_range(0, 99) < 55 && cur < TABLE_ENTRIES - 1)
				cur = cur + 1;
			else
				cur = $urandom_range(0, TABLE_ENTRIES - 1);
			links.push_back(cur);
		end
		sel = $urandom_range(0, 99);
		if (sel < 70 || used_q.size() == 0)
			term = $urandom_range(int'(END_MARK), 16'hFFFF);
		else if (sel < 85)
			term = $urandom_range(TABLE_ENTRIES, int'(END_MARK) - 1);
		else
			term = pick_written();
		for (k = 0; k < len - 1; k++)
			push_load(links[k], links[k + 1]);
		push_load(links[len - 1], term);
		push_walk(links[0], pick_cap());
		if ($urandom_range(0, 1) == 1)
			push_walk(links[$urandom_range(0, len - 1)], pick_cap());
	endtask

	task automatic add_random();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			add_chain();
		else if (sel < 70)
			push_walk(pick_written(), pick_cap());
		else if (sel < 80)
			push_walk($urandom_range(TABLE_ENTRIES, 16'hFFFF), pick_cap());
		else if ($urandom_range(0, 1) == 0)
			push_load($urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(TABLE_ENTRIES, 16'hFFFF));
		else
			push_load($urandom_range(0, TABLE_ENTRIES - 1), pick_written());
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || in_valid || extent_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int idle, input int stall, input int n, input bit hold);
		@(negedge clk);
		idle_pct = idle;
		stall_pct = stall;
		pushed = 0;
		while (pushed < n)
			add_random();
		if (hold)
			hold_arm = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reserved clusters as start
		push_load(0, 1);
		push_load(1, 16'hFFFF);
		push_walk(0, 1);
		// consecutive run running off the table end
		push_load(4094, 4095);
		push_load(4095, 16'h1000);
		push_walk(4094, 16);
		push_walk(16'hFFFF, 31);
		// capacity and resume
		push_load(10, 11);
		push_load(11, 20);
		push_load(20, int'(END_MARK));
		push_walk(10, 0);
		push_walk(10, 2);
		push_walk(20, 16);
		// value just below end mark
		push_load(30, 16'hFFF7);
		push_walk(30, 2);
		push_walk(30, 1);
		// self loop fills every extent slot
		push_load(100, 100);
		push_walk(100, 16);
		push_walk(100, 31);
		push_load(12'hFFF, 16'hFFFF);
		push_walk(12'hFFF, 3);
		push_load(200, 0);
		push_walk(200, 4);
		wait_drained();
		run_phase(0, 0, 60, 1'b1);
		run_phase(67, 0, 70, 1'b0);
		run_phase(0, 67, 70, 1'b0);
		run_phase(19, 19, 60, 1'b0);
		if (err_count == 0)
			$display("PASS fat16_chain_extent_builder_core");
		else
			$display("FAIL fat16_chain_extent_builder_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fce_pkg.sv
design/fce_ctrl.sv
design/fce_dpath.sv
design/fat16_chain_extent_builder_core.sv
sim/fat16_chain_extent_builder_core_tb.sv
